>>> sv/gpac_pkg.sv
// gpac_pkg: shared types and constants for the autocorrelation checker
// no dependencies; imported by every module of the block

package gpac_pkg;

   localparam int SEQ_LEN   = 7;
   localparam int IN_ELEMS  = SEQ_LEN - 1;
   localparam int EL_W      = 3;
   localparam int TAIL_W    = 6;
   localparam int TARGET_W  = 8;
   localparam int SHIFT_W   = 3;
   localparam int HALF_SH   = (SEQ_LEN - 1) / 2;
   // one conjugate product term: two products of up to 24 * 4, summed
   localparam int TERM_W    = 9;
   localparam int PROD_W    = 2 * TAIL_W;
   // seven terms of up to 192 each
   localparam int SUM_W     = 12;
   localparam int ABS_SUM_W = 6;
   localparam logic [ABS_SUM_W-1:0] DOMAIN_MAX = ABS_SUM_W'(3);

   localparam logic signed [TARGET_W-1:0] TARGET_RE_RESET = -8'sd3;
   localparam logic signed [TARGET_W-1:0] TARGET_IM_RESET = 8'sd0;

   typedef enum logic {
      CSR_TARGET_REAL = 1'b0,
      CSR_TARGET_IMAG = 1'b1
   } csr_index_type;

   // one classified candidate as it travels from front to back
   typedef struct packed {
      logic [IN_ELEMS-1:0][EL_W-1:0] el_re;
      logic [IN_ELEMS-1:0][EL_W-1:0] el_im;
      logic signed [TAIL_W-1:0]      tail_re;
      logic signed [TAIL_W-1:0]      tail_im;
      logic                          tail_in_domain;
   } gpac_item_type;

endpackage

>>> sv/gaussian_periodic_autocorrelation_check.sv
// Candidate checker for length-7 Gaussian-integer sequences. Each request word carries six
// elements; the block derives the seventh as the negated sum, flags whether it is a sum of
// three fourth roots of unity, and if so checks the periodic autocorrelation at shifts 1..6
// against the target held in two csr registers (index 0 real, index 1 imaginary, reset -3
// and 0). It takes one word per clock while req_ready is high and returns one response
// word per request in order; a response passes through the intake register, a queue
// slot, the product-term register and the compare/output register.
// The rate is set by the back pipeline, which advances whenever the output register is
// empty or being drained. The queue (QUEUE_DEPTH words, 1 to 32) lets the intake keep
// taking words for a while when the response side stalls. Targets are read live, so csr
// writes belong to idle periods.
// depends on gpac_pkg, gpac_front, gpac_queue, gpac_back

module gaussian_periodic_autocorrelation_check import gpac_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [EL_W-1:0]     req_e0_re,
   input  logic signed [EL_W-1:0]     req_e0_im,
   input  logic signed [EL_W-1:0]     req_e1_re,
   input  logic signed [EL_W-1:0]     req_e1_im,
   input  logic signed [EL_W-1:0]     req_e2_re,
   input  logic signed [EL_W-1:0]     req_e2_im,
   input  logic signed [EL_W-1:0]     req_e3_re,
   input  logic signed [EL_W-1:0]     req_e3_im,
   input  logic signed [EL_W-1:0]     req_e4_re,
   input  logic signed [EL_W-1:0]     req_e4_im,
   input  logic signed [EL_W-1:0]     req_e5_re,
   input  logic signed [EL_W-1:0]     req_e5_im,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [TAIL_W-1:0]   rsp_tail_re,
   output logic signed [TAIL_W-1:0]   rsp_tail_im,
   output logic                       rsp_tail_in_domain,
   output logic                       rsp_all_match,
   output logic [SHIFT_W-1:0]         rsp_first_bad_shift,
   // csr write port
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [TARGET_W-1:0]        csr_wdata
);

   // target registers
   logic signed [TARGET_W-1:0] target_re_ff, target_re_in;
   logic signed [TARGET_W-1:0] target_im_ff, target_im_in;

   // front to queue, queue to back
   logic          front_valid, front_ready;
   gpac_item_type front_item;
   logic          head_valid, head_pop;
   gpac_item_type head_item;

   always_comb begin
      target_re_in = target_re_ff;
      target_im_in = target_im_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TARGET_REAL: target_re_in = $signed(csr_wdata);
            CSR_TARGET_IMAG: target_im_in = $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_re_ff <= TARGET_RE_RESET;
         target_im_ff <= TARGET_IM_RESET;
      end else begin
         target_re_ff <= target_re_in;
         target_im_ff <= target_im_in;
      end
   end

   // intake and classification
   gpac_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_e0_re  (req_e0_re),
      .req_e0_im  (req_e0_im),
      .req_e1_re  (req_e1_re),
      .req_e1_im  (req_e1_im),
      .req_e2_re  (req_e2_re),
      .req_e2_im  (req_e2_im),
      .req_e3_re  (req_e3_re),
      .req_e3_im  (req_e3_im),
      .req_e4_re  (req_e4_re),
      .req_e4_im  (req_e4_im),
      .req_e5_re  (req_e5_re),
      .req_e5_im  (req_e5_im),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item       (front_item)
   );

   // decoupling queue, lets front and back stall independently
   gpac_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop        (head_pop),
      .pop_valid  (head_valid),
      .pop_item   (head_item)
   );

   // autocorrelation and compare pipeline with output register
   gpac_back u_back (
      .clock               (clock),
      .reset               (reset),
      .item_valid          (head_valid),
      .item                (head_item),
      .item_pop            (head_pop),
      .target_re           (target_re_ff),
      .target_im           (target_im_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_tail_re         (rsp_tail_re),
      .rsp_tail_im         (rsp_tail_im),
      .rsp_tail_in_domain  (rsp_tail_in_domain),
      .rsp_all_match       (rsp_all_match),
      .rsp_first_bad_shift (rsp_first_bad_shift)
   );

`ifndef SYNTHESIS
   // a full match needs an in-domain tail and no failing shift
   a_match_needs_domain : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_all_match |-> rsp_tail_in_domain && (rsp_first_bad_shift == '0))
      else $error("match reported without domain or with a failing shift");

   // out-of-domain words never name a failing shift
   a_no_shift_off_domain : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tail_in_domain |-> !rsp_all_match && (rsp_first_bad_shift == '0))
      else $error("shift or match reported for out-of-domain tail");

   // in domain: either everything matches or some shift is named
   a_domain_verdict : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tail_in_domain |-> rsp_all_match || (rsp_first_bad_shift != '0))
      else $error("in-domain word with neither match nor failing shift");

   // domain flag agrees with the tail parity
   a_domain_parity : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tail_in_domain |-> (rsp_tail_re[0] ^ rsp_tail_im[0]))
      else $error("domain flag set for even tail");

   // nothing comes out right after reset
   a_quiet_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule

>>> sv/gpac_front.sv
// gpac_front: intake register, forms the seventh element and the domain flag
// depends on gpac_pkg

module gpac_front import gpac_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [EL_W-1:0] req_e0_re,
   input  logic signed [EL_W-1:0] req_e0_im,
   input  logic signed [EL_W-1:0] req_e1_re,
   input  logic signed [EL_W-1:0] req_e1_im,
   input  logic signed [EL_W-1:0] req_e2_re,
   input  logic signed [EL_W-1:0] req_e2_im,
   input  logic signed [EL_W-1:0] req_e3_re,
   input  logic signed [EL_W-1:0] req_e3_im,
   input  logic signed [EL_W-1:0] req_e4_re,
   input  logic signed [EL_W-1:0] req_e4_im,
   input  logic signed [EL_W-1:0] req_e5_re,
   input  logic signed [EL_W-1:0] req_e5_im,
   output logic                   item_valid,
   input  logic                   item_ready,
   output gpac_item_type          item
);

   logic          front_valid_ff, front_valid_in;
   gpac_item_type front_item_ff, front_item_in;
   logic          take;

   logic signed [TAIL_W-1:0]    sum_re, sum_im;
   logic        [TAIL_W-1:0]    abs_re, abs_im;
   logic        [ABS_SUM_W-1:0] abs_sum;

   assign req_ready = !front_valid_ff || item_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      sum_re = TAIL_W'(req_e0_re) + TAIL_W'(req_e1_re) + TAIL_W'(req_e2_re)
             + TAIL_W'(req_e3_re) + TAIL_W'(req_e4_re) + TAIL_W'(req_e5_re);
      sum_im = TAIL_W'(req_e0_im) + TAIL_W'(req_e1_im) + TAIL_W'(req_e2_im)
             + TAIL_W'(req_e3_im) + TAIL_W'(req_e4_im) + TAIL_W'(req_e5_im);
      abs_re  = sum_re[TAIL_W-1] ? TAIL_W'(-sum_re) : TAIL_W'(sum_re);
      abs_im  = sum_im[TAIL_W-1] ? TAIL_W'(-sum_im) : TAIL_W'(sum_im);
      abs_sum = ABS_SUM_W'(abs_re + abs_im);

      front_item_in.el_re = {req_e5_re, req_e4_re, req_e3_re,
                             req_e2_re, req_e1_re, req_e0_re};
      front_item_in.el_im = {req_e5_im, req_e4_im, req_e3_im,
                             req_e2_im, req_e1_im, req_e0_im};
      front_item_in.tail_re = -sum_re;
      front_item_in.tail_im = -sum_im;
      // sum of three unit roots: small l1 norm and odd coordinate sum
      front_item_in.tail_in_domain = (abs_sum <= DOMAIN_MAX) && (sum_re[0] ^ sum_im[0]);
   end

   assign front_valid_in = take || (front_valid_ff && !item_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         front_item_ff <= front_item_in;
      end
   end

   assign item_valid = front_valid_ff;
   assign item       = front_item_ff;

endmodule

>>> sv/gpac_queue.sv
// gpac_queue: short register queue between the front and back parts
// depends on gpac_pkg

module gpac_queue import gpac_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  gpac_item_type push_item,
   input  logic          pop,
   output logic          pop_valid,
   output gpac_item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   gpac_item_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> sv/gpac_back.sv
// gpac_back: conjugate product terms, autocorrelation sums, target compare
// depends on gpac_pkg

module gpac_back import gpac_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       item_valid,
   input  gpac_item_type              item,
   output logic                       item_pop,
   input  logic signed [TARGET_W-1:0] target_re,
   input  logic signed [TARGET_W-1:0] target_im,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [TAIL_W-1:0]   rsp_tail_re,
   output logic signed [TAIL_W-1:0]   rsp_tail_im,
   output logic                       rsp_tail_in_domain,
   output logic                       rsp_all_match,
   output logic [SHIFT_W-1:0]         rsp_first_bad_shift
);

   logic advance;

   // term stage
   logic                     term_valid_ff, term_valid_in;
   logic signed [TERM_W-1:0] term_re_ff [HALF_SH][SEQ_LEN];
   logic signed [TERM_W-1:0] term_im_ff [HALF_SH][SEQ_LEN];
   logic signed [TERM_W-1:0] term_re_in [HALF_SH][SEQ_LEN];
   logic signed [TERM_W-1:0] term_im_in [HALF_SH][SEQ_LEN];
   logic signed [TAIL_W-1:0] term_tail_re_ff, term_tail_im_ff;
   logic                     term_dom_ff;

   // output stage
   logic                     out_valid_ff, out_valid_in;
   logic signed [TAIL_W-1:0] out_tail_re_ff, out_tail_im_ff;
   logic                     out_dom_ff, out_match_ff, out_match_in;
   logic [SHIFT_W-1:0]       out_bad_ff, out_bad_in;

   logic signed [TAIL_W-1:0] x_re [SEQ_LEN];
   logic signed [TAIL_W-1:0] x_im [SEQ_LEN];
   logic signed [SUM_W-1:0]  acc_re [HALF_SH];
   logic signed [SUM_W-1:0]  acc_im [HALF_SH];
   logic [SEQ_LEN-1:1]       miss;
   logic signed [SUM_W-1:0]  tgt_re, tgt_im;

   assign advance       = !out_valid_ff || rsp_ready;
   assign item_pop      = advance && item_valid;
   assign term_valid_in = advance ? item_valid : term_valid_ff;
   assign out_valid_in  = advance ? term_valid_ff : out_valid_ff;

   // products x[k] * conj(x[k+s]) for s = 1..3; s = 4..6 are their conjugates
   always_comb begin
      int j;
      logic signed [PROD_W-1:0] p_re, p_im;
      for (int k = 0; k < IN_ELEMS; k++) begin
         x_re[k] = TAIL_W'($signed(item.el_re[k]));
         x_im[k] = TAIL_W'($signed(item.el_im[k]));
      end
      x_re[SEQ_LEN-1] = item.tail_re;
      x_im[SEQ_LEN-1] = item.tail_im;
      for (int s = 0; s < HALF_SH; s++) begin
         for (int k = 0; k < SEQ_LEN; k++) begin
            j = k + s + 1;
            if (j >= SEQ_LEN) begin
               j = j - SEQ_LEN;
            end
            p_re = x_re[k] * x_re[j] + x_im[k] * x_im[j];
            p_im = x_im[k] * x_re[j] - x_re[k] * x_im[j];
            term_re_in[s][k] = p_re[TERM_W-1:0];
            term_im_in[s][k] = p_im[TERM_W-1:0];
         end
      end
   end

   always_comb begin
      tgt_re = SUM_W'(target_re);
      tgt_im = SUM_W'(target_im);
      for (int s = 0; s < HALF_SH; s++) begin
         acc_re[s] = '0;
         acc_im[s] = '0;
         for (int k = 0; k < SEQ_LEN; k++) begin
            acc_re[s] = acc_re[s] + SUM_W'(term_re_ff[s][k]);
            acc_im[s] = acc_im[s] + SUM_W'(term_im_ff[s][k]);
         end
         miss[s+1]         = (acc_re[s] != tgt_re) || (acc_im[s] != tgt_im);
         miss[SEQ_LEN-1-s] = (acc_re[s] != tgt_re) || (-acc_im[s] != tgt_im);
      end
      out_bad_in = '0;
      for (int s = SEQ_LEN - 1; s >= 1; s--) begin
         if (miss[s]) begin
            out_bad_in = SHIFT_W'(s);
         end
      end
      if (!term_dom_ff) begin
         out_bad_in = '0;
      end
      out_match_in = term_dom_ff && (miss == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         term_valid_ff <= term_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         term_re_ff      <= term_re_in;
         term_im_ff      <= term_im_in;
         term_tail_re_ff <= item.tail_re;
         term_tail_im_ff <= item.tail_im;
         term_dom_ff     <= item.tail_in_domain;
         out_tail_re_ff  <= term_tail_re_ff;
         out_tail_im_ff  <= term_tail_im_ff;
         out_dom_ff      <= term_dom_ff;
         out_match_ff    <= out_match_in;
         out_bad_ff      <= out_bad_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_tail_re         = out_tail_re_ff;
   assign rsp_tail_im         = out_tail_im_ff;
   assign rsp_tail_in_domain  = out_dom_ff;
   assign rsp_all_match       = out_match_ff;
   assign rsp_first_bad_shift = out_bad_ff;

endmodule
